// ===== sv/sfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the scrambled frame receiver.
// ----------------------------------------------------------------------------

package sfr_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_ADDR    = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TYPE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_GOOD    = 2'd2,
		KIND_BAD     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_HEADER_CODE   = 2'd0,
		REG_OWN_ADDRESS   = 2'd1,
		REG_SCRAMBLE_SEED = 2'd2,
		REG_RESYNC_TYPE   = 2'd3
	} reg_index_t;

	localparam logic        FUNC_BYTE   = 1'b0;
	localparam logic        FUNC_RESYNC = 1'b1;

	localparam logic [31:0] LCG_MUL     = 32'd1103515245;
	localparam logic [31:0] LCG_ADD     = 32'd12345;
	localparam logic [7:0]  CNT_STEP    = 8'd101;
	localparam logic [7:0]  CNT_INIT    = 8'd31;
	localparam logic [31:0] SEED_INIT   = 32'd333;

	// bytes ahead of the payload that byte_count includes (address, type)
	// plus the length-to-payload offset
	localparam logic [7:0]  HDR_BYTES   = 8'd3;
	localparam logic [7:0]  MIN_PAY_LEN = 8'd3;

endpackage

`default_nettype wire

// ===== sv/scrambled_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scrambled_frame_receiver
// Frames link bytes, checks header, address and checksum, descrambles payload.
// ----------------------------------------------------------------------------
// One transaction is taken per clock unless item_stall is high. A byte is
// captured in an input register; then the frame state machine, the checksum
// adder and the keystream generator (one 32x32 constant multiply) update
// together and write the result register when it can advance, so a result
// is registered behind the input register. The result register decouples the
// two channels: a new byte is accepted while a finished result waits, and
// item_stall rises only when the input register is occupied while a result
// sits stalled in the result register. The keystream persists across frames
// unless a good frame of the resync type reloads it; func = 1 reloads it from
// scramble_seed and restarts header hunting without producing a result.

module scrambled_frame_receiver
	import sfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,

	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        func,
	input  wire logic [7:0]  rx_byte,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic [7:0]       value,
	output logic [7:0]       payload_index
);

	logic [7:0]  header_code_q;
	logic [7:0]  own_address_q;
	logic [31:0] scramble_seed_q;
	logic [7:0]  resync_type_q;

	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q,  phase_d;
	logic [7:0]  sum_q,    sum_d;
	logic [7:0]  len_q,    len_d;
	logic [7:0]  bc_q,     bc_d;
	logic [7:0]  fkind_q,  fkind_d;
	logic [31:0] lcg_q,    lcg_d;
	logic [7:0]  cnt_q,    cnt_d;

	logic        out_valid_q;
	kind_t       kind_q,   kind_d;
	logic [7:0]  value_q,  value_d;
	logic [7:0]  index_q,  index_d;
	logic        has_res;

	logic        adv;
	logic        fire;
	logic [31:0] lcg_prod;
	logic [31:0] lcg_step;
	logic [7:0]  cnt_step;
	logic [7:0]  key;
	logic [7:0]  bc_inc;
	logic [8:0]  bc_next2;
	logic        good;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_code_q   <= '0;
			own_address_q   <= '0;
			scramble_seed_q <= SEED_INIT;
			resync_type_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_CODE:   header_code_q   <= cfg_data[7:0];
				REG_OWN_ADDRESS:   own_address_q   <= cfg_data[7:0];
				REG_SCRAMBLE_SEED: scramble_seed_q <= cfg_data;
				REG_RESYNC_TYPE:   resync_type_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign adv        = !out_valid_q || !result_stall;
	assign fire       = valid_s1 && adv;
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	assign lcg_prod = lcg_q * LCG_MUL + LCG_ADD;
	assign lcg_step = {8'd0, lcg_prod[31:8]};
	assign cnt_step = cnt_q + CNT_STEP;
	assign key      = cnt_step ^ lcg_prod[15:8];
	assign bc_inc   = bc_q + 8'd1;
	assign bc_next2 = {1'b0, bc_inc} + 9'd1;
	assign good     = (byte_s1 == sum_q) && (bc_inc == len_q);

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		bc_d    = bc_q;
		fkind_d = fkind_q;
		lcg_d   = lcg_q;
		cnt_d   = cnt_q;
		has_res = 1'b0;
		kind_d  = KIND_TYPE;
		value_d = byte_s1;
		index_d = '0;
		if (fire) begin
			if (func_s1 == FUNC_RESYNC) begin
				lcg_d   = scramble_seed_q;
				cnt_d   = CNT_INIT;
				phase_d = PH_HUNT;
				sum_d   = '0;
				len_d   = '0;
				bc_d    = '0;
				fkind_d = '0;
			end else begin
				case (phase_q)
					PH_LEN: begin
						sum_d   = sum_q + byte_s1;
						len_d   = byte_s1;
						bc_d    = '0;
						phase_d = PH_ADDR;
					end
					PH_ADDR: begin
						sum_d   = sum_q + byte_s1;
						bc_d    = bc_inc;
						phase_d = (byte_s1 == own_address_q) ? PH_TYPE : PH_HUNT;
					end
					PH_TYPE: begin
						sum_d   = sum_q + byte_s1;
						bc_d    = bc_inc;
						fkind_d = byte_s1;
						phase_d = (len_q > MIN_PAY_LEN) ? PH_PAYLOAD : PH_CHECK;
						has_res = 1'b1;
						kind_d  = KIND_TYPE;
					end
					PH_PAYLOAD: begin
						lcg_d   = lcg_step;
						cnt_d   = cnt_step;
						sum_d   = sum_q + byte_s1;
						bc_d    = bc_inc;
						if (bc_next2 >= {1'b0, len_q}) begin
							phase_d = PH_CHECK;
						end
						has_res = 1'b1;
						kind_d  = KIND_PAYLOAD;
						value_d = byte_s1 ^ key;
						index_d = bc_inc - HDR_BYTES;
					end
					PH_CHECK: begin
						bc_d    = bc_inc;
						sum_d   = sum_q + byte_s1;
						phase_d = PH_HUNT;
						if (good && fkind_q == resync_type_q) begin
							lcg_d = scramble_seed_q;
							cnt_d = CNT_INIT;
						end
						has_res = 1'b1;
						kind_d  = good ? KIND_GOOD : KIND_BAD;
						index_d = (bc_inc >= HDR_BYTES) ? bc_inc - HDR_BYTES : 8'd0;
					end
					default: begin
						sum_d   = byte_s1;
						phase_d = (byte_s1 == header_code_q) ? PH_LEN : PH_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			len_q   <= '0;
			bc_q    <= '0;
			fkind_q <= '0;
			lcg_q   <= SEED_INIT;
			cnt_q   <= CNT_INIT;
		end else begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			bc_q    <= bc_d;
			fkind_q <= fkind_d;
			lcg_q   <= lcg_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			index_q <= index_d;
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = kind_q;
	assign value         = value_q;
	assign payload_index = index_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled without both stages occupied");

	a_resync_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_s1 == FUNC_RESYNC |=> phase_q == PH_HUNT && cnt_q == CNT_INIT)
		else $error("resync did not restart hunting");

	a_type_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_s1 == FUNC_BYTE && phase_q == PH_TYPE
		|=> result_valid && kind == KIND_TYPE && payload_index == 8'd0)
		else $error("type byte did not produce a type result");

	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_HUNT && !result_stall |=> !result_valid)
		else $error("result produced while hunting");

endmodule

`default_nettype wire
